// ===== sv/bmcr_pkg.sv =====
// Shared constants, types and state codes of the background model change-ratio unit.
package bmcr_pkg;

  localparam int unsigned ImgWidth    = 96;
  localparam int unsigned ImgHeight   = 96;
  localparam int unsigned ImgChannels = 1;
  localparam int unsigned FramePixels = ImgWidth * ImgHeight * ImgChannels;
  localparam int unsigned PosW        = (FramePixels > 1) ? $clog2(FramePixels) : 1;

  localparam int unsigned PixW   = 8;
  localparam int unsigned BgW    = 16;
  localparam int unsigned CfgW   = 8;
  localparam int unsigned CountW = 14;
  localparam int unsigned RatioW = 17;

  // Serial divider sizes: tally shifted by 16 over a divisor of up to CountW bits.
  localparam int unsigned DvdW = CountW + 16;
  localparam int unsigned DvsW = CountW;
  localparam int unsigned StepW = $clog2(DvdW + 1);

  localparam logic [CfgW-1:0] WindowReset    = 8'd8;
  localparam logic [CfgW-1:0] ThresholdReset = 8'd20;

  typedef enum logic [0:0] {
    CfgWindow    = 1'b0,
    CfgThreshold = 1'b1
  } bmcr_cfg_e;

  typedef enum logic [0:0] {
    OpUpdate  = 1'b0,
    OpCompare = 1'b1
  } bmcr_op_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StFetch,
    StDivUpd,
    StDivRatio
  } bmcr_state_e;

endpackage

// ===== sv/background_model_change_ratio_unit.sv =====
// Per-pixel running-average background with change count and ratio report.
// Update request: fetch, the serial divider steps and a write back, before the next is accepted.
// Compare request: fetch, then back to idle; the last pixel of a frame also runs the ratio
// division, and waits further while the previous report still sits on the result port.
// Throughput is set by the single shared serial divider, one quotient bit per cycle.
// After reset the background memory is cleared one entry per cycle, all 9216 entries,
// during which no request is accepted; configuration writes are taken at any time.
module background_model_change_ratio_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [bmcr_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic signed [bmcr_pkg::PixW-1:0] pixel_i,
  input  logic                           frame_end_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bmcr_pkg::CountW-1:0]    changed_pixels_o,
  output logic [bmcr_pkg::RatioW-1:0]    change_ratio_o
);

  bmcr_pkg::bmcr_state_e state_q, state_d;

  logic [bmcr_pkg::CfgW-1:0]   win_q, win_d;
  logic [bmcr_pkg::CfgW-1:0]   thr_q, thr_d;
  logic [bmcr_pkg::PosW-1:0]   pos_q, pos_d;
  logic [bmcr_pkg::PosW-1:0]   clr_q, clr_d;
  logic [bmcr_pkg::CfgW-1:0]   frames_q, frames_d;
  logic [bmcr_pkg::CountW-1:0] tally_q, tally_d;
  logic [bmcr_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic [bmcr_pkg::CountW-1:0] out_cnt_q, out_cnt_d;
  logic [bmcr_pkg::RatioW-1:0] out_ratio_q, out_ratio_d;

  logic [bmcr_pkg::PosW-1:0]   addr_q, addr_d;
  logic                        op_q, op_d;
  logic [bmcr_pkg::PixW-1:0]   pix_q, pix_d;
  logic                        end_q, end_d;
  logic [bmcr_pkg::BgW-1:0]    bg_q, bg_d;
  logic                        neg_q, neg_d;

  logic [bmcr_pkg::BgW-1:0]    bg_mem [bmcr_pkg::FramePixels];
  logic [bmcr_pkg::BgW-1:0]    rd_q;
  logic                        mem_we;
  logic [bmcr_pkg::PosW-1:0]   mem_waddr;
  logic [bmcr_pkg::BgW-1:0]    mem_wdata;

  logic                        div_start;
  logic [bmcr_pkg::DvdW-1:0]   div_dvd;
  logic [bmcr_pkg::DvsW-1:0]   div_dvs;
  logic                        div_done;
  logic [bmcr_pkg::DvdW-1:0]   div_quot;

  logic                        in_acc;
  logic                        in_end;
  logic [bmcr_pkg::CfgW-1:0]   n_eff;
  logic                        warm;
  logic [17:0]                 p_ext;
  logic [17:0]                 bg_ext;
  logic [17:0]                 num;
  logic [16:0]                 mag;
  logic [17:0]                 diff;
  logic [16:0]                 absd;
  logic                        changed;
  logic [bmcr_pkg::CountW-1:0] tally_new;
  logic [17:0]                 add;
  logic [18:0]                 sum;
  logic [bmcr_pkg::BgW-1:0]    sum_sat;
  logic                        out_free;

  assign in_ready_o = (state_q == bmcr_pkg::StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_end     = frame_end_i || (pos_q == bmcr_pkg::PosW'(bmcr_pkg::FramePixels - 1));
  assign n_eff      = (win_q == '0) ? bmcr_pkg::CfgW'(1) : win_q;
  assign warm       = (frames_q >= n_eff);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    // Pixel in Q8.8 and the stored background, both widened to 18 bits.
    p_ext     = {{2{pix_q[bmcr_pkg::PixW-1]}}, pix_q, 8'b0};
    bg_ext    = {{2{rd_q[bmcr_pkg::BgW-1]}}, rd_q};
    num       = warm ? (p_ext - bg_ext) : p_ext;
    mag       = num[17] ? 17'(-num) : num[16:0];
    diff      = bg_ext - p_ext;
    absd      = diff[17] ? 17'(-diff) : diff[16:0];
    changed   = (absd > {1'b0, thr_q, 8'b0});
    tally_new = tally_q + bmcr_pkg::CountW'(changed);
    add       = neg_q ? 18'(-{1'b0, div_quot[16:0]}) : {1'b0, div_quot[16:0]};
    sum       = {{3{bg_q[bmcr_pkg::BgW-1]}}, bg_q} + {add[17], add};
    if (sum[18:15] == 4'b0000 || sum[18:15] == 4'b1111) begin
      sum_sat = sum[15:0];
    end else begin
      sum_sat = sum[18] ? 16'h8000 : 16'h7FFF;
    end
  end

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    thr_d       = thr_q;
    pos_d       = pos_q;
    clr_d       = clr_q;
    frames_d    = frames_q;
    tally_d     = tally_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_cnt_d   = out_cnt_q;
    out_ratio_d = out_ratio_q;
    addr_d      = addr_q;
    op_d        = op_q;
    pix_d       = pix_q;
    end_d       = end_q;
    bg_d        = bg_q;
    neg_d       = neg_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = sum_sat;
    div_start   = 1'b0;
    div_dvd     = {{(bmcr_pkg::DvdW-17){1'b0}}, mag};
    div_dvs     = {{(bmcr_pkg::DvsW-bmcr_pkg::CfgW){1'b0}}, n_eff};

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmcr_pkg::CfgWindow:    win_d = cfg_data_i;
        bmcr_pkg::CfgThreshold: thr_d = cfg_data_i;
        default:                ;
      endcase
    end

    unique case (state_q)
      bmcr_pkg::StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == bmcr_pkg::PosW'(bmcr_pkg::FramePixels - 1)) begin
          state_d = bmcr_pkg::StIdle;
        end
      end
      bmcr_pkg::StIdle: begin
        if (in_acc) begin
          addr_d  = pos_q;
          op_d    = op_i;
          pix_d   = pixel_i;
          end_d   = in_end;
          pos_d   = in_end ? '0 : pos_q + 1'b1;
          state_d = bmcr_pkg::StFetch;
        end
      end
      bmcr_pkg::StFetch: begin
        // The registered memory read of the request's position is valid here.
        bg_d = rd_q;
        if (op_q == bmcr_pkg::OpUpdate) begin
          neg_d     = num[17];
          div_start = 1'b1;
          state_d   = bmcr_pkg::StDivUpd;
        end else if (end_q) begin
          cnt_d     = tally_new;
          tally_d   = '0;
          div_dvd   = {tally_new, 16'b0};
          div_dvs   = bmcr_pkg::DvsW'(addr_q) + 1'b1;
          div_start = 1'b1;
          state_d   = bmcr_pkg::StDivRatio;
        end else begin
          tally_d = tally_new;
          state_d = bmcr_pkg::StIdle;
        end
      end
      bmcr_pkg::StDivUpd: begin
        if (div_done) begin
          mem_we = 1'b1;
          if (end_q) begin
            tally_d = '0;
            if (frames_q < n_eff) begin
              frames_d = frames_q + 1'b1;
            end
          end
          state_d = bmcr_pkg::StIdle;
        end
      end
      bmcr_pkg::StDivRatio: begin
        if (div_done && out_free) begin
          out_valid_d = 1'b1;
          out_cnt_d   = cnt_q;
          out_ratio_d = div_quot[bmcr_pkg::RatioW-1:0];
          state_d     = bmcr_pkg::StIdle;
        end
      end
      default: state_d = bmcr_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmcr_pkg::StClear;
      win_q       <= bmcr_pkg::WindowReset;
      thr_q       <= bmcr_pkg::ThresholdReset;
      pos_q       <= '0;
      clr_q       <= '0;
      frames_q    <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      thr_q       <= thr_d;
      pos_q       <= pos_d;
      clr_q       <= clr_d;
      frames_q    <= frames_d;
      tally_q     <= tally_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    out_cnt_q   <= out_cnt_d;
    out_ratio_q <= out_ratio_d;
    addr_q      <= addr_d;
    op_q        <= op_d;
    pix_q       <= pix_d;
    end_q       <= end_d;
    bg_q        <= bg_d;
    neg_q       <= neg_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bg_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= bg_mem[pos_q];
  end

  bmcr_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign out_valid_o      = out_valid_q;
  assign changed_pixels_o = out_cnt_q;
  assign change_ratio_o   = out_ratio_q;

endmodule

// ===== sv/bmcr_divider.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module bmcr_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bmcr_pkg::DvdW-1:0]    dividend_i,
  input  logic [bmcr_pkg::DvsW-1:0]    divisor_i,
  output logic                         done_o,
  output logic [bmcr_pkg::DvdW-1:0]    quotient_o
);

  logic [bmcr_pkg::DvdW-1:0]  acc_q, acc_d;
  logic [bmcr_pkg::DvsW-1:0]  rem_q, rem_d;
  logic [bmcr_pkg::DvsW-1:0]  dvs_q, dvs_d;
  logic [bmcr_pkg::StepW-1:0] step_q, step_d;
  logic                       done_q, done_d;
  logic [bmcr_pkg::DvsW:0]    rem_sh;
  logic [bmcr_pkg::DvsW:0]    rem_sub;
  logic                       fits;

  always_comb begin
    rem_sh  = {rem_q, acc_q[bmcr_pkg::DvdW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
    acc_d   = acc_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    step_d  = step_q;
    done_d  = done_q;
    if (start_i) begin
      acc_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      step_d = bmcr_pkg::StepW'(bmcr_pkg::DvdW);
      done_d = 1'b0;
    end else if (step_q != '0) begin
      acc_d  = {acc_q[bmcr_pkg::DvdW-2:0], fits};
      // The remainder stays below the divisor, so its top bit is always zero.
      rem_d  = fits ? rem_sub[bmcr_pkg::DvsW-1:0] : rem_sh[bmcr_pkg::DvsW-1:0];
      step_d = step_q - 1'b1;
      done_d = (step_q == bmcr_pkg::StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule
